// ----- rtl/core/mcaf_pkg.sv -----
// Shared types, codes and constants for the converter calibration and filter block.
`default_nettype none

package mcaf_pkg;

    // channel store
    localparam int CHANNELS = 12;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W     = 4;

    // item codes
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_GAIN   = 2'd1;
    localparam logic [1:0] CMD_OFFSET = 2'd2;
    localparam logic [1:0] CMD_FILTER = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_IGN  = 2'd2;

    // reset codes and accepted ranges
    localparam logic [13:0] GAIN_RST   = 14'd10018;
    localparam logic [15:0] OFFSET_RST = 16'd20000;
    localparam logic [14:0] FILTER_RST = 15'd10000;

    localparam logic [15:0] GAIN_LO   = 16'd9801;
    localparam logic [15:0] GAIN_HI   = 16'd10199;
    localparam logic [15:0] OFFSET_LO = 16'd1;
    localparam logic [15:0] OFFSET_HI = 16'd39999;
    localparam logic [15:0] FILTER_LO = 16'd1;
    localparam logic [15:0] FILTER_HI = 16'd19999;

    localparam logic [15:0] ONE_CODE    = 16'd10000;
    localparam logic [16:0] OFFSET_ZERO = 17'd20000;

    // 65535 * 10000 and twice that
    localparam logic [29:0] FULL_ONE  = 30'd655350000;
    localparam logic [30:0] FULL_ONE2 = 31'd1310700000;

    // floor(2^62 / FULL_ONE2), reciprocal for the scaling quotient
    localparam logic [31:0] RECIP_V = 32'((64'd1 << 62) / 64'(FULL_ONE2));

    // serial divider
    localparam int NUM_W = 52;              // numerator magnitude
    localparam int DSH_W = 53;              // aligned divisor
    localparam int Q_W   = 33;              // quotient magnitude
    localparam int QUO_W = Q_W + 1;         // signed quotient
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] S_ITERS = 6'd33;

    typedef struct packed {
        logic [13:0]        gain;
        logic [15:0]        offset;
        logic [14:0]        filter;
        logic signed [31:0] result;
    } row_t;

    localparam row_t ROW_RST = '{
        gain:   GAIN_RST,
        offset: OFFSET_RST,
        filter: FILTER_RST,
        result: 32'sd0
    };

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [NUM_W-1:0] mag;
        logic [DSH_W-1:0] den;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/mcaf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mcaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                          clk,
    input  wire                                          we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]                              wdata,
    input  wire                                          re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mcaf_div.sv -----
// Bit-serial signed floor divider, one quotient bit per cycle.
`default_nettype none

module mcaf_div (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire mcaf_pkg::div_req_t   req,
    output mcaf_pkg::div_rsp_t        rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [mcaf_pkg::CNT_W-1:0]          cnt_reg;
    logic                                neg_reg;
    logic [mcaf_pkg::NUM_W-1:0]          rem_reg;
    logic [mcaf_pkg::DSH_W-1:0]          dsh_reg;
    logic [mcaf_pkg::Q_W-1:0]            q_reg;

    logic                                fits;
    logic [mcaf_pkg::DSH_W-1:0]          rem_next;

    assign fits     = {1'b0, rem_reg} >= dsh_reg;
    assign rem_next = {1'b0, rem_reg} - dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == mcaf_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.neg;
            rem_reg <= req.mag;
            dsh_reg <= req.den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_next[mcaf_pkg::NUM_W-1:0];
            end
            q_reg   <= {q_reg[mcaf_pkg::Q_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // floor for a negative numerator: -q when exact, else -q-1
    always_comb
    begin
        rsp.done = done_reg;
        if (!neg_reg)
        begin
            rsp.quo = $signed({1'b0, q_reg});
        end
        else if (|rem_reg)
        begin
            rsp.quo = $signed(~{1'b0, q_reg});
        end
        else
        begin
            rsp.quo = -$signed({1'b0, q_reg});
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/multichannel_adc_calibrate_filter.sv -----
// Top level: per-channel converter calibration and first-order low-pass filter.
//
//   Input channel (item_valid / item_ready) carries one beat per item: cmd,
//   channel, sample and code. A sample beat scales the raw code with the
//   channel's gain and offset, runs one filter step and reports the
//   filtered value in thousandths. Set beats replace one calibration code.
//   Output channel (result_valid / result_ready) returns exactly one beat
//   per item, in order.
//   A sample beat's filter step runs through a one-bit-per-cycle divider
//   (33 quotient bits); the constant scaling is a reciprocal multiply with
//   one correction step, plus the read-modify-write of the channel row.
//   The next beat is taken the cycle after a result is loaded.
//   One item is in flight at a time; the output register holds a finished
//   result while the next item is accepted and worked on. A stalled
//   receiver only holds the block at the point of loading the next result.
//   Reset clears the channel valid bits, so every channel reads as its
//   reset codes and a zero filtered value; no clearing pass is needed.
`default_nettype none

module multichannel_adc_calibrate_filter (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         item_valid,
    output logic        item_ready,
    input  wire  [1:0]  cmd,
    input  wire  [3:0]  channel,
    input  wire  [15:0] sample,
    input  wire  [15:0] code,
    output logic        result_valid,
    input  wire         result_ready,
    output logic [3:0]  out_channel,
    output logic [15:0] ma_code,
    output logic [1:0]  status,
    output logic        saturated
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_SET   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_VNUM  = 4'd4;
    localparam logic [3:0] S_VST   = 4'd5;
    localparam logic [3:0] S_VEST  = 4'd6;
    localparam logic [3:0] S_VREM  = 4'd7;
    localparam logic [3:0] S_VFIX  = 4'd8;
    localparam logic [3:0] S_VDIF  = 4'd9;
    localparam logic [3:0] S_SMUL  = 4'd10;
    localparam logic [3:0] S_SST   = 4'd11;
    localparam logic [3:0] S_SDIV  = 4'd12;
    localparam logic [3:0] S_MA    = 4'd13;
    localparam logic [3:0] S_CLAMP = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;
    logic [mcaf_pkg::CHANNELS-1:0]  vld_reg;
    logic                           result_valid_reg;

    // item held while it is worked on
    logic [1:0]                     cmd_reg;
    logic [3:0]                     ch_reg;
    logic [15:0]                    code_reg;
    logic [20:0]                    smp_reg;     // raw code times 25
    logic [mcaf_pkg::ADDR_W-1:0]    addr_reg;
    mcaf_pkg::row_t                 row_reg;

    // arithmetic pipeline registers
    logic [34:0]                    prod_reg;
    logic signed [32:0]             offm_reg;
    logic signed [35:0]             num_reg;
    logic [51:0]                    vmag_reg;
    logic                           vneg_reg;
    logic [21:0]                    qe_reg;
    logic [32:0]                    vrem_reg;
    logic signed [33:0]             v_reg;
    logic signed [33:0]             diff_reg;
    logic signed [48:0]             sprod_reg;
    logic signed [31:0]             nr_reg;
    logic signed [41:0]             mprod_reg;

    // result under construction and output register
    logic [1:0]                     rs_status_reg;
    logic [15:0]                    rs_ma_reg;
    logic                           rs_sat_reg;
    logic [3:0]                     out_channel_reg;
    logic [15:0]                    ma_code_reg;
    logic [1:0]                     status_reg;
    logic                           saturated_reg;

    logic                           accept;
    logic                           ch_ok;
    logic                           out_free;

    logic                           ram_we;
    logic [mcaf_pkg::ADDR_W-1:0]    ram_raddr;
    mcaf_pkg::row_t                 ram_wdata;
    mcaf_pkg::row_t                 ram_rdata;
    mcaf_pkg::row_t                 row_rd;

    mcaf_pkg::div_req_t             div_req;
    mcaf_pkg::div_rsp_t             div_rsp;

    // set item decode
    logic [15:0]                    set_cur;
    logic                           set_ok;
    logic                           set_same;
    logic                           set_store;
    mcaf_pkg::row_t                 set_row;
    mcaf_pkg::row_t                 upd_row;

    // datapath nets
    logic signed [16:0]             off17;
    logic signed [52:0]             vn;
    logic [51:0]                    vmag;
    logic [63:0]                    qe_prod;
    logic [32:0]                    vqd;
    logic                           vfits;
    logic                           vexact;
    logic [33:0]                    vq;
    logic [15:0]                    fil_full;
    logic signed [48:0]             sn;
    logic [48:0]                    smag;
    logic signed [34:0]             nr_w;
    logic signed [41:0]             msum;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign ch_ok      = {1'b0, channel} < 5'(mcaf_pkg::CHANNELS);
    assign out_free   = !result_valid_reg || result_ready;

    // ---------------------------------------------------------------
    // Channel row store: one row per channel, unwritten rows read as reset
    // ---------------------------------------------------------------
    assign ram_raddr = channel[mcaf_pkg::ADDR_W-1:0];

    mcaf_ram #(
        .WIDTH ($bits(mcaf_pkg::row_t)),
        .DEPTH (mcaf_pkg::CHANNELS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign row_rd = vld_reg[addr_reg] ? ram_rdata : mcaf_pkg::ROW_RST;

    // ---------------------------------------------------------------
    // Set items: equal check first, then range check
    // ---------------------------------------------------------------
    always_comb
    begin
        set_cur = '0;
        set_ok  = 1'b0;
        set_row = row_reg;
        case (cmd_reg)
            mcaf_pkg::CMD_GAIN:
            begin
                set_cur      = {2'b00, row_reg.gain};
                set_ok       = code_reg inside {[mcaf_pkg::GAIN_LO:mcaf_pkg::GAIN_HI]};
                set_row.gain = code_reg[13:0];
            end
            mcaf_pkg::CMD_OFFSET:
            begin
                set_cur        = row_reg.offset;
                set_ok         = code_reg inside {[mcaf_pkg::OFFSET_LO:mcaf_pkg::OFFSET_HI]};
                set_row.offset = code_reg;
            end
            mcaf_pkg::CMD_FILTER:
            begin
                set_cur        = {1'b0, row_reg.filter};
                set_ok         = code_reg inside {[mcaf_pkg::FILTER_LO:mcaf_pkg::FILTER_HI]};
                set_row.filter = code_reg[14:0];
            end
            default:
            begin
                set_ok = 1'b0;
            end
        endcase
    end

    assign set_same  = (code_reg == set_cur);
    assign set_store = !set_same && set_ok;

    always_comb
    begin
        upd_row        = row_reg;
        upd_row.result = nr_reg;
    end

    assign ram_we    = ((state_reg == S_SET) && set_store) || (state_reg == S_MA);
    assign ram_wdata = (state_reg == S_MA) ? upd_row : set_row;

    // ---------------------------------------------------------------
    // Sample arithmetic
    // v    = floor((num*2^17 + F) / 2F),  F = 65535*10000
    //        estimate from the top 32 bits of |n| times floor(2^62/2F),
    //        low by at most one, then one compare and subtract
    // step = floor((2*(v-r)*10000 + fil) / 2fil), serial divider
    // ---------------------------------------------------------------
    assign off17    = $signed({1'b0, row_reg.offset}) - $signed(mcaf_pkg::OFFSET_ZERO);
    assign vn       = $signed({num_reg, 17'd0}) + $signed({23'd0, mcaf_pkg::FULL_ONE});
    assign vmag     = vn[52] ? 52'(-vn) : 52'(vn);
    assign qe_prod  = 64'(vmag_reg[51:20]) * 64'(mcaf_pkg::RECIP_V);
    // remainder is below 2^32, so the low 33 bits are enough
    assign vqd      = 33'(qe_reg) * 33'(mcaf_pkg::FULL_ONE2);
    assign vfits    = vrem_reg >= 33'(mcaf_pkg::FULL_ONE2);
    assign vexact   = vfits ? (vrem_reg == 33'(mcaf_pkg::FULL_ONE2)) : (vrem_reg == '0);
    assign vq       = 34'(qe_reg) + 34'(vfits);
    assign fil_full = {1'b0, row_reg.filter} + mcaf_pkg::ONE_CODE;
    assign sn       = sprod_reg + $signed({33'd0, fil_full});
    assign smag     = sn[48] ? 49'(-sn) : 49'(sn);
    assign nr_w     = 35'(row_reg.result) + 35'(div_rsp.quo);
    assign msum     = mprod_reg + 42'sd32768;

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.neg   = 1'b0;
        div_req.mag   = '0;
        div_req.den   = '0;
        div_req.iters = '0;
        case (state_reg)
            S_SST:
            begin
                div_req.start = 1'b1;
                div_req.neg   = sn[48];
                div_req.mag   = {3'd0, smag};
                div_req.den   = {36'd0, fil_full, 1'b0} << (mcaf_pkg::S_ITERS - 1'b1);
                div_req.iters = mcaf_pkg::S_ITERS;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    mcaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ch_ok ? S_READ : S_FIN;
                end
            end
            S_READ:  state_next = (cmd_reg == mcaf_pkg::CMD_SAMPLE) ? S_MUL : S_SET;
            S_SET:   state_next = S_FIN;
            S_MUL:   state_next = S_VNUM;
            S_VNUM:  state_next = S_VST;
            S_VST:   state_next = S_VEST;
            S_VEST:  state_next = S_VREM;
            S_VREM:  state_next = S_VFIX;
            S_VFIX:  state_next = S_VDIF;
            S_VDIF:  state_next = S_SMUL;
            S_SMUL:  state_next = S_SST;
            S_SST:   state_next = S_SDIV;
            S_SDIV:  state_next = div_rsp.done ? S_MA : S_SDIV;
            S_MA:    state_next = S_CLAMP;
            S_CLAMP: state_next = S_FIN;
            S_FIN:   state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg       <= cmd;
                    ch_reg        <= channel;
                    code_reg      <= code;
                    smp_reg       <= 21'(sample) * 21'd25;
                    addr_reg      <= channel[mcaf_pkg::ADDR_W-1:0];
                    rs_status_reg <= ch_ok ? mcaf_pkg::ST_DONE : mcaf_pkg::ST_IGN;
                    rs_ma_reg     <= '0;
                    rs_sat_reg    <= 1'b0;
                end
            end
            S_READ:
            begin
                row_reg <= row_rd;
            end
            S_SET:
            begin
                if (set_same)
                begin
                    rs_status_reg <= mcaf_pkg::ST_SAME;
                end
                else if (!set_ok)
                begin
                    rs_status_reg <= mcaf_pkg::ST_IGN;
                end
                else
                begin
                    rs_status_reg <= mcaf_pkg::ST_DONE;
                end
            end
            S_MUL:
            begin
                prod_reg <= 35'(smp_reg) * 35'(row_reg.gain);
                offm_reg <= (33'(off17) <<< 16) - 33'(off17);
            end
            S_VNUM:
            begin
                num_reg <= $signed({1'b0, prod_reg}) - 36'(offm_reg);
            end
            S_VST:
            begin
                vmag_reg <= vmag;
                vneg_reg <= vn[52];
            end
            S_VEST:
            begin
                qe_reg <= qe_prod[63:42];
            end
            S_VREM:
            begin
                vrem_reg <= vmag_reg[32:0] - vqd;
            end
            S_VFIX:
            begin
                // floor for a negative numerator: -q when exact, else -q-1
                if (!vneg_reg)
                begin
                    v_reg <= $signed(vq);
                end
                else if (vexact)
                begin
                    v_reg <= -$signed(vq);
                end
                else
                begin
                    v_reg <= $signed(~vq);
                end
            end
            S_VDIF:
            begin
                diff_reg <= v_reg - 34'(row_reg.result);
            end
            S_SMUL:
            begin
                sprod_reg <= 49'(diff_reg) * 49'sd20000;
            end
            S_SDIV:
            begin
                if (div_rsp.done)
                begin
                    // clamp to the signed 32-bit range
                    if (nr_w[34:31] == 4'b0000 || nr_w[34:31] == 4'b1111)
                    begin
                        nr_reg <= nr_w[31:0];
                    end
                    else if (nr_w[34])
                    begin
                        nr_reg <= 32'sh8000_0000;
                    end
                    else
                    begin
                        nr_reg <= 32'sh7FFF_FFFF;
                    end
                end
            end
            S_MA:
            begin
                mprod_reg <= 42'(nr_reg) * 42'sd1000;
            end
            S_CLAMP:
            begin
                if (msum[41])
                begin
                    rs_ma_reg  <= '0;
                    rs_sat_reg <= 1'b1;
                end
                else if (|msum[40:32])
                begin
                    rs_ma_reg  <= 16'hFFFF;
                    rs_sat_reg <= 1'b1;
                end
                else
                begin
                    rs_ma_reg  <= msum[31:16];
                    rs_sat_reg <= 1'b0;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_channel_reg <= ch_reg;
                    ma_code_reg     <= rs_ma_reg;
                    status_reg      <= rs_status_reg;
                    saturated_reg   <= rs_sat_reg;
                end
            end
            default:
            begin
                nr_reg <= nr_reg;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign out_channel  = out_channel_reg;
    assign ma_code      = ma_code_reg;
    assign status       = status_reg;
    assign saturated    = saturated_reg;

`ifndef SYNTHESIS
    // divider only reports back while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_SDIV))
        else $error("divider finished outside a wait state");

    // the row store is written only for an item on a valid channel
    a_we_channel: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ch_reg} < 5'(mcaf_pkg::CHANNELS)))
        else $error("row store written for a channel out of range");

    // unchanged and ignored beats never carry a filtered value
    a_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != mcaf_pkg::ST_DONE) |-> (ma_code == 16'd0 && !saturated))
        else $error("non-sample result carries a value");

    // a clamped value sits at one end of the range
    a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |-> (ma_code == 16'd0 || ma_code == 16'hFFFF))
        else $error("saturated flag with an interior value");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the converter calibration and low-pass filter block.
`timescale 1ns / 100ps

module tb_top;

    // Run limit in clock cycles.
    localparam int CYCLE_LIMIT = 1000000;

    // Scaling constants of the calibration arithmetic
    localparam longint FULL_SCALE  = 64'sd65535;     // converter full-scale code
    localparam longint SPAN_VOLTS  = 64'sd25;        // full scale maps to 25
    localparam longint UNITY       = 64'sd10000;     // calibration code for 1.0
    localparam longint ZERO_OFFSET = 64'sd20000;     // offset code for 0.0
    localparam longint Q_ONE       = 64'sd65536;     // 1.0 in Q16.16
    localparam longint MILLI       = 64'sd1000;
    localparam longint INT32_TOP   = 64'sd2147483647;
    localparam longint INT32_BOT   = -64'sd2147483648;

    // One result beat as the block should report it
    typedef struct {
        logic [3:0]  chan;
        logic [15:0] ma;
        logic [1:0]  st;
        logic        sat;
    } reading_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic [1:0]  cmd          = mcaf_pkg::CMD_SAMPLE;
    logic [3:0]  channel      = 4'd0;
    logic [15:0] sample       = 16'd0;
    logic [15:0] code         = 16'd0;
    logic        result_ready = 1'b0;
    logic        item_ready;
    logic        result_valid;
    logic [3:0]  out_channel;
    logic [15:0] ma_code;
    logic [1:0]  status;
    logic        saturated;

    // Our own copy of the per-channel calibration and filter state
    logic [13:0]        gain_code   [mcaf_pkg::CHANNELS];
    logic [15:0]        offset_code [mcaf_pkg::CHANNELS];
    logic [14:0]        filter_code [mcaf_pkg::CHANNELS];
    logic signed [31:0] level_q16   [mcaf_pkg::CHANNELS];

    reading_t pending_readings[$];
    reading_t want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    multichannel_adc_calibrate_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .channel      (channel),
        .sample       (sample),
        .code         (code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_channel  (out_channel),
        .ma_code      (ma_code),
        .status       (status),
        .saturated    (saturated)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Arithmetic helpers: floor division and round-half-up division
    // ---------------------------------------------------------------
    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint round_quot(longint a, longint b);
        return floor_quot(2 * a + b, 2 * b);
    endfunction

    // Accepted window of a set command
    function automatic void code_window(input logic [1:0] c,
                                        output logic [15:0] lo,
                                        output logic [15:0] hi);
        case (c)
            mcaf_pkg::CMD_GAIN:
            begin
                lo = mcaf_pkg::GAIN_LO;
                hi = mcaf_pkg::GAIN_HI;
            end
            mcaf_pkg::CMD_OFFSET:
            begin
                lo = mcaf_pkg::OFFSET_LO;
                hi = mcaf_pkg::OFFSET_HI;
            end
            default:
            begin
                lo = mcaf_pkg::FILTER_LO;
                hi = mcaf_pkg::FILTER_HI;
            end
        endcase
    endfunction

    // Code currently held for a set command on a valid channel
    function automatic logic [15:0] held_code(logic [1:0] c, logic [3:0] ch);
        case (c)
            mcaf_pkg::CMD_GAIN:   return 16'(gain_code[ch]);
            mcaf_pkg::CMD_OFFSET: return offset_code[ch];
            default:              return 16'(filter_code[ch]);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Predictor: applies one item to the local state and returns the
    // beat the block must answer with.
    // ---------------------------------------------------------------
    function automatic reading_t predict_reading(logic [1:0] c, logic [3:0] ch,
                                                 logic [15:0] s, logic [15:0] k);
        reading_t   rd;
        longint     gain, offs, fdiv, numer, volts, prev, step, next, milli;
        logic [15:0] lo, hi, held;
        rd.chan = ch;
        rd.ma   = 16'd0;
        rd.st   = mcaf_pkg::ST_DONE;
        rd.sat  = 1'b0;
        if (ch >= mcaf_pkg::CHANNELS)
        begin
            // unknown channel: nothing touched, whatever the command
            rd.st = mcaf_pkg::ST_IGN;
        end
        else if (c == mcaf_pkg::CMD_SAMPLE)
        begin
            gain  = longint'(gain_code[ch]);
            offs  = longint'(offset_code[ch]) - ZERO_OFFSET;
            fdiv  = longint'(filter_code[ch]) + UNITY;
            numer = longint'(s) * SPAN_VOLTS * gain - offs * FULL_SCALE;
            volts = round_quot(numer * Q_ONE, FULL_SCALE * UNITY);
            prev  = longint'(level_q16[ch]);
            step  = round_quot((volts - prev) * UNITY, fdiv);
            next  = prev + step;
            if (next > INT32_TOP)
                next = INT32_TOP;
            if (next < INT32_BOT)
                next = INT32_BOT;
            level_q16[ch] = next[31:0];
            milli = floor_quot(next * MILLI + Q_ONE / 2, Q_ONE);
            if (milli < 0)
            begin
                milli  = 0;
                rd.sat = 1'b1;
            end
            else if (milli > FULL_SCALE)
            begin
                milli  = FULL_SCALE;
                rd.sat = 1'b1;
            end
            rd.ma = milli[15:0];
        end
        else
        begin
            code_window(c, lo, hi);
            held = held_code(c, ch);
            if (k == held)
            begin
                rd.st = mcaf_pkg::ST_SAME;
            end
            else if (k < lo || k > hi)
            begin
                rd.st = mcaf_pkg::ST_IGN;
            end
            else
            begin
                // filtered value is kept across a calibration change
                case (c)
                    mcaf_pkg::CMD_GAIN:   gain_code[ch]   = k[13:0];
                    mcaf_pkg::CMD_OFFSET: offset_code[ch] = k;
                    default:              filter_code[ch] = k[14:0];
                endcase
            end
        end
        return rd;
    endfunction

    // ---------------------------------------------------------------
    // Sender: optional idle cycles, then hold the beat until taken.
    // The expectation is queued at the accepting edge.
    // ---------------------------------------------------------------
    task automatic send_item(input logic [1:0] c, input logic [3:0] ch,
                             input logic [15:0] s, input logic [15:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= c;
        channel    <= ch;
        sample     <= s;
        code       <= k;
        do
            @(posedge clk);
        while (!item_ready);
        pending_readings.push_back(predict_reading(c, ch, s, k));
    endtask

    // ---------------------------------------------------------------
    // Receiver: random back-pressure, and every result beat checked
    // field by field against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, channel %0d ma_code %0d status %0d",
                         $time, out_channel, ma_code, status);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (out_channel !== want.chan)
                begin
                    mismatches++;
                    $display("%0t: out_channel expected %0d actual %0d",
                             $time, want.chan, out_channel);
                end
                if (ma_code !== want.ma)
                begin
                    mismatches++;
                    $display("%0t: ch %0d ma_code expected %0d actual %0d",
                             $time, want.chan, want.ma, ma_code);
                end
                if (status !== want.st)
                begin
                    mismatches++;
                    $display("%0t: ch %0d status expected %0d actual %0d",
                             $time, want.chan, want.st, status);
                end
                if (saturated !== want.sat)
                begin
                    mismatches++;
                    $display("%0t: ch %0d saturated expected %0d actual %0d",
                             $time, want.chan, want.sat, saturated);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------

    // Fresh channels: reset gain, zero offset, filter 1.0, zero level.
    task automatic test_reset_state();
        send_item(mcaf_pkg::CMD_SAMPLE, 4'd0, 16'h0000, 16'h0000);
        send_item(mcaf_pkg::CMD_SAMPLE, 4'd11, 16'hFFFF, 16'hFFFF);
        send_item(mcaf_pkg::CMD_SAMPLE, 4'd0, 16'hFFFF, 16'h0000);
    endtask

    // Window edges of every set command, plus a repeat of the held code.
    task automatic test_calibration_limits();
        send_item(mcaf_pkg::CMD_GAIN, 4'd1, 16'h1234, 16'd9800);
        send_item(mcaf_pkg::CMD_GAIN, 4'd1, 16'h0000, 16'd9801);
        send_item(mcaf_pkg::CMD_GAIN, 4'd1, 16'h0000, 16'd9801);   // unchanged
        send_item(mcaf_pkg::CMD_GAIN, 4'd1, 16'h0000, 16'd10199);
        send_item(mcaf_pkg::CMD_GAIN, 4'd1, 16'h0000, 16'd10200);
        send_item(mcaf_pkg::CMD_OFFSET, 4'd1, 16'h0000, 16'd0);
        send_item(mcaf_pkg::CMD_OFFSET, 4'd1, 16'h0000, 16'd1);
        send_item(mcaf_pkg::CMD_OFFSET, 4'd1, 16'h0000, 16'd40000);
        send_item(mcaf_pkg::CMD_OFFSET, 4'd1, 16'h0000, 16'd39999);
        send_item(mcaf_pkg::CMD_FILTER, 4'd1, 16'h0000, 16'd0);
        send_item(mcaf_pkg::CMD_FILTER, 4'd1, 16'h0000, 16'd20000);
        send_item(mcaf_pkg::CMD_FILTER, 4'd1, 16'h0000, 16'd1);
        send_item(mcaf_pkg::CMD_FILTER, 4'd1, 16'h0000, 16'd19999);
        send_item(mcaf_pkg::CMD_FILTER, 4'd1, 16'hFFFF, 16'hFFFF);
    endtask

    // Negative level clamps the reading at zero; a full-scale sample with the
    // lowest offset code and the fastest filter drives the reading high unclamped.
    task automatic test_clamping();
        send_item(mcaf_pkg::CMD_OFFSET, 4'd2, 16'h0000, 16'd39999);
        send_item(mcaf_pkg::CMD_SAMPLE, 4'd2, 16'h0000, 16'h0000);
        send_item(mcaf_pkg::CMD_OFFSET, 4'd3, 16'h0000, 16'd1);
        send_item(mcaf_pkg::CMD_FILTER, 4'd3, 16'h0000, 16'd1);
        send_item(mcaf_pkg::CMD_SAMPLE, 4'd3, 16'hFFFF, 16'h0000);
    endtask

    // Channel indexes past the store are refused for every command.
    task automatic test_bad_channel();
        send_item(mcaf_pkg::CMD_SAMPLE, 4'd12, 16'hFFFF, 16'hFFFF);
        send_item(mcaf_pkg::CMD_GAIN,   4'd13, 16'h0000, 16'd10000);
        send_item(mcaf_pkg::CMD_OFFSET, 4'd14, 16'h0000, 16'd20001);
        send_item(mcaf_pkg::CMD_FILTER, 4'd15, 16'hFFFF, 16'd5000);
    endtask

    // ---------------------------------------------------------------
    // Random traffic: mostly samples, a steady share of calibration
    // changes (mostly accepted, some repeats, edges and junk codes)
    // and a few beats to channels that do not exist.
    // ---------------------------------------------------------------
    task automatic test_random_traffic(input int beats);
        logic [1:0]  c;
        logic [3:0]  ch;
        logic [15:0] s, k, lo, hi;
        int          pick;
        for (int n = 0; n < beats; n++)
        begin
            pick = $urandom_range(99);
            s    = 16'($urandom());
            k    = 16'($urandom());
            if ($urandom_range(9) == 0)
                s = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
            if (pick < 5)
            begin
                c  = 2'($urandom_range(3));
                ch = 4'($urandom_range(15, mcaf_pkg::CHANNELS));
            end
            else if (pick < 70)
            begin
                c  = mcaf_pkg::CMD_SAMPLE;
                ch = 4'($urandom_range(mcaf_pkg::CHANNELS - 1));
            end
            else
            begin
                c  = 2'($urandom_range(3, 1));
                ch = 4'($urandom_range(mcaf_pkg::CHANNELS - 1));
                code_window(c, lo, hi);
                pick = $urandom_range(99);
                if (pick < 60)
                    k = 16'($urandom_range(hi, lo));
                else if (pick < 75)
                    k = held_code(c, ch);
                else if (pick < 90)
                    case ($urandom_range(3))
                        0:       k = lo - 16'd1;
                        1:       k = lo;
                        2:       k = hi;
                        default: k = hi + 16'd1;
                    endcase
            end
            send_item(c, ch, s, k);
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < mcaf_pkg::CHANNELS; i++)
        begin
            gain_code[i]   = mcaf_pkg::GAIN_RST;
            offset_code[i] = mcaf_pkg::OFFSET_RST;
            filter_code[i] = mcaf_pkg::FILTER_RST;
            level_q16[i]   = 32'sd0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // light sender gaps, heavy back-pressure
        send_idle_pct = 23;
        recv_idle_pct = 78;
        test_reset_state();
        test_calibration_limits();
        test_clamping();
        test_bad_channel();
        test_random_traffic(460);

        // heavy sender gaps, light back-pressure
        send_idle_pct = 78;
        recv_idle_pct = 23;
        test_random_traffic(460);

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(460);

        item_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        // allow for a stray beat
        repeat (150) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/mcaf_pkg.sv
rtl/core/mcaf_ram.sv
rtl/core/mcaf_div.sv
rtl/core/multichannel_adc_calibrate_filter.sv
tb/tb_top.sv
